// ===== src/tlv_body_check_and_find_assert.svh =====
// Assertion macros shared by the checker of tlv_body_check_and_find.
// No dependencies; included by the checker file only.
`ifndef TLV_BODY_CHECK_AND_FIND_ASSERT_SVH
`define TLV_BODY_CHECK_AND_FIND_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TLVBC_ASSERT_NOW(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("tlvbc assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define TLVBC_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("tlvbc assertion failed");

`endif

// ===== src/tlvbc_pkg.sv =====
// Package for tlv_body_check_and_find: widths, phase codes, word and result types.
// No dependencies.
package tlvbc_pkg;

    localparam int unsigned BODY_HEAD_BYTES_DEF = 1;
    localparam int unsigned RECORD_HEAD_BYTES   = 4;
    localparam int unsigned S_TDATA_W           = 32;
    localparam int unsigned S_TUSER_W           = 2;
    localparam int unsigned M_TDATA_W           = 56;
    localparam int unsigned M_TUSER_W           = 2;

    typedef enum logic [4:0] {
        PH_IDLE  = 5'b00001,
        PH_HEAD  = 5'b00010,
        PH_RHEAD = 5'b00100,
        PH_VALUE = 5'b01000,
        PH_DONE  = 5'b10000
    } phase_t;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        first_byte;
        logic        last_byte;
        logic        func;
        logic [15:0] query_type;
        logic [7:0]  start_index;
    } item_t;

    typedef struct packed {
        logic        body_valid;
        logic        found;
        logic [7:0]  match_index;
        logic [15:0] match_offset;
        logic [15:0] match_length;
        logic [8:0]  next_index;
    } result_t;

endpackage

// ===== src/tlvbc_parse.sv =====
// Byte-wise TLV body parser: holds the scan state and forms the result on the last byte.
// Depends on tlvbc_pkg.
module tlvbc_parse
    import tlvbc_pkg::*;
#(
    parameter int unsigned BODY_HEAD_BYTES = BODY_HEAD_BYTES_DEF
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    step,
    input  item_t   item,
    output logic    res_valid,
    output result_t res
);

    localparam logic [1:0] FIELD_LAST = 2'(RECORD_HEAD_BYTES - 1);

    phase_t      phase_reg, phase_cur, phase_next;
    logic [15:0] pos_reg, pos_cur, pos_next;
    logic [7:0]  total_reg, total_cur, total_next;
    logic [7:0]  index_reg, index_cur, index_next;
    logic [1:0]  fcnt_reg, fcnt_cur, fcnt_next;
    logic [15:0] type_reg, type_cur, type_next;
    logic [15:0] vleft_reg, vleft_cur, vleft_next;
    logic        func_reg, func_cur;
    logic [15:0] qtype_reg, qtype_cur;
    logic [7:0]  qstart_reg, qstart_cur;
    logic        mfound_reg, mfound_cur, mfound_next;
    logic [7:0]  midx_reg, midx_cur, midx_next;
    logic [15:0] moff_reg, moff_cur, moff_next;
    logic [15:0] mlen_reg, mlen_cur, mlen_next;
    logic [15:0] pos_inc;

    always_comb begin
        phase_cur  = phase_reg;
        pos_cur    = pos_reg;
        total_cur  = total_reg;
        index_cur  = index_reg;
        fcnt_cur   = fcnt_reg;
        type_cur   = type_reg;
        vleft_cur  = vleft_reg;
        func_cur   = func_reg;
        qtype_cur  = qtype_reg;
        qstart_cur = qstart_reg;
        mfound_cur = mfound_reg;
        midx_cur   = midx_reg;
        moff_cur   = moff_reg;
        mlen_cur   = mlen_reg;
        if (item.first_byte) begin
            phase_cur  = PH_HEAD;
            pos_cur    = '0;
            total_cur  = '0;
            index_cur  = '0;
            fcnt_cur   = '0;
            type_cur   = '0;
            vleft_cur  = '0;
            func_cur   = item.func;
            qtype_cur  = item.query_type;
            qstart_cur = item.start_index;
            mfound_cur = 1'b0;
            midx_cur   = '0;
            moff_cur   = '0;
            mlen_cur   = '0;
        end
    end

    assign pos_inc = pos_cur + 16'd1;

    always_comb begin
        phase_next  = phase_cur;
        pos_next    = pos_cur;
        total_next  = total_cur;
        index_next  = index_cur;
        fcnt_next   = fcnt_cur;
        type_next   = type_cur;
        vleft_next  = vleft_cur;
        mfound_next = mfound_cur;
        midx_next   = midx_cur;
        moff_next   = moff_cur;
        mlen_next   = mlen_cur;
        res_valid   = 1'b0;
        res         = '0;
        if (phase_cur != PH_IDLE) begin
            if (pos_cur != 16'hFFFF) begin
                pos_next = pos_inc;
                case (phase_cur)
                    PH_HEAD: begin
                        if (pos_cur == 16'd0) begin
                            total_next = item.data_byte;
                        end
                        if ({1'b0, pos_inc} >= 17'(BODY_HEAD_BYTES)) begin
                            if (total_next == 8'd0) begin
                                phase_next = PH_DONE;
                            end else begin
                                phase_next = PH_RHEAD;
                                fcnt_next  = '0;
                            end
                        end
                    end
                    PH_RHEAD: begin
                        case (fcnt_cur)
                            2'd0:    type_next  = {item.data_byte, 8'h00};
                            2'd1:    type_next  = {type_cur[15:8], item.data_byte};
                            2'd2:    vleft_next = {item.data_byte, 8'h00};
                            default: vleft_next = {vleft_cur[15:8], item.data_byte};
                        endcase
                        if (fcnt_cur == FIELD_LAST) begin
                            fcnt_next = '0;
                            if (!mfound_cur && index_cur >= qstart_cur &&
                                (func_cur || type_next == qtype_cur)) begin
                                mfound_next = 1'b1;
                                midx_next   = index_cur;
                                moff_next   = pos_inc;
                                mlen_next   = vleft_next;
                            end
                            index_next = index_cur + 8'd1;
                            if (vleft_next == 16'd0) begin
                                phase_next = (index_next >= total_cur) ? PH_DONE : PH_RHEAD;
                            end else begin
                                phase_next = PH_VALUE;
                            end
                        end else begin
                            fcnt_next = fcnt_cur + 2'd1;
                        end
                    end
                    PH_VALUE: begin
                        vleft_next = vleft_cur - 16'd1;
                        if (vleft_next == 16'd0) begin
                            fcnt_next  = '0;
                            phase_next = (index_cur >= total_cur) ? PH_DONE : PH_RHEAD;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (item.last_byte) begin
                res_valid        = 1'b1;
                res.body_valid   = (phase_next == PH_DONE);
                res.found        = mfound_next;
                res.match_index  = midx_next;
                res.match_offset = moff_next;
                res.match_length = mlen_next;
                res.next_index   = mfound_next ? ({1'b0, midx_next} + 9'd1) : 9'd0;
                phase_next       = PH_IDLE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
        end else if (step) begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            pos_reg    <= pos_next;
            total_reg  <= total_next;
            index_reg  <= index_next;
            fcnt_reg   <= fcnt_next;
            type_reg   <= type_next;
            vleft_reg  <= vleft_next;
            func_reg   <= func_cur;
            qtype_reg  <= qtype_cur;
            qstart_reg <= qstart_cur;
            mfound_reg <= mfound_next;
            midx_reg   <= midx_next;
            moff_reg   <= moff_next;
            mlen_reg   <= mlen_next;
        end
    end

endmodule

// ===== src/tlv_body_check_and_find.sv =====
// Top level of the TLV body checker and record finder: input register, parser, result register.
// Depends on tlvbc_pkg and tlvbc_parse.
//
//   channel | dir | handshake          | payload
//   s_      | in  | s_tvalid/s_tready  | s_tdata, s_tuser, s_tlast  one body byte per word
//   m_      | out | m_tvalid/m_tready  | m_tdata, m_tuser           one result per body
//
// One word per cycle while m_tready does not hold the result; the last byte of a body is
// loaded into the input register at acceptance, and its result into the result register after it.
// aresetn clears the word valid flags and the parser phase.
// m_tready low holds the result; the input register still takes one more word if it is empty.
module tlv_body_check_and_find
    import tlvbc_pkg::*;
#(
    parameter int unsigned BODY_HEAD_BYTES = BODY_HEAD_BYTES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // data_byte[7:0], query_type[23:8], start_index[31:24]
    input  logic [S_TUSER_W-1:0] s_tuser,  // first_byte[0], func[1]
    input  logic                 s_tlast,  // last_byte
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,  // match_index[7:0], match_offset[23:8],
                                           // match_length[39:24], next_index[48:40], zero
    output logic [M_TUSER_W-1:0] m_tuser   // body_valid[0], found[1]
);

    logic    in_valid_reg, in_valid_next;
    item_t   item_reg;
    logic    out_valid_reg, out_valid_next;
    result_t res_reg;
    logic    advance;
    logic    step;
    logic    res_valid;
    result_t res;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign step     = in_valid_reg && advance;

    assign in_valid_next  = s_tready ? s_tvalid : in_valid_reg;
    assign out_valid_next = advance ? (step && res_valid) : out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.data_byte   <= s_tdata[7:0];
            item_reg.query_type  <= s_tdata[23:8];
            item_reg.start_index <= s_tdata[31:24];
            item_reg.first_byte  <= s_tuser[0];
            item_reg.func        <= s_tuser[1];
            item_reg.last_byte   <= s_tlast;
        end
        if (advance) begin
            res_reg <= res;
        end
    end

    tlvbc_parse #(
        .BODY_HEAD_BYTES(BODY_HEAD_BYTES)
    ) u_parse (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .item      (item_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, res_reg.next_index, res_reg.match_length,
                       res_reg.match_offset, res_reg.match_index};
    assign m_tuser  = {res_reg.found, res_reg.body_valid};

endmodule

// ===== src/tlvbc_checker.sv =====
// Port-level checker for tlv_body_check_and_find, attached by bind.
// Depends on tlvbc_pkg and tlv_body_check_and_find_assert.svh.
`include "tlv_body_check_and_find_assert.svh"

module tlvbc_port_asserts
    import tlvbc_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [S_TDATA_W-1:0] s_tdata,
    input logic [S_TUSER_W-1:0] s_tuser,
    input logic                 s_tlast,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [M_TUSER_W-1:0] m_tuser
);

    logic unused_in;
    assign unused_in = ^{s_tvalid, s_tready, s_tdata, s_tuser, s_tlast};

    `TLVBC_ASSERT_NEXT(a_hold_result, aclk, aresetn, m_tvalid && !m_tready,
                       m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    `TLVBC_ASSERT_NOW(a_miss_zero, aclk, aresetn, m_tvalid && !m_tuser[1],
                      m_tdata[48:0] == 49'd0)
    `TLVBC_ASSERT_NOW(a_next_index, aclk, aresetn, m_tvalid && m_tuser[1],
                      m_tdata[48:40] == ({1'b0, m_tdata[7:0]} + 9'd1))
    `TLVBC_ASSERT_NOW(a_pad_zero, aclk, aresetn, m_tvalid, m_tdata[55:49] == 7'd0)

endmodule

bind tlv_body_check_and_find tlvbc_port_asserts u_checker (.*);

// ===== dv/tlvbc_checker.sv =====
`timescale 1ns / 1ps
// Result checker for tlv_body_check_and_find: follows every accepted body word,
// predicts the result word of each body and compares it with the m_ channel.
// Depends on tlvbc_pkg.
module tlvbc_checker
    import tlvbc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [S_TUSER_W-1:0] s_tuser,
    input  logic                 s_tlast,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    input  logic [M_TUSER_W-1:0] m_tuser,
    output int                   fail_count,
    output int                   pending_count
);

    result_t     awaited_results[$];
    int          mismatches = 0;

    phase_t      scan_phase = PH_IDLE;
    logic [15:0] byte_pos   = '0;
    logic [7:0]  rec_total  = '0;
    logic [7:0]  rec_idx    = '0;
    logic [1:0]  hdr_cnt    = '0;
    logic [15:0] rec_type   = '0;
    logic [15:0] value_left = '0;
    logic        q_by_pos   = 1'b0;
    logic [15:0] q_type     = '0;
    logic [7:0]  q_start    = '0;
    result_t     hit        = '0;

    initial begin
        fail_count    = 0;
        pending_count = 0;
    end

    function automatic int field_diff(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge aclk) begin : track
        logic [7:0]  b;
        logic [15:0] pos_now;
        result_t     want;
        result_t     got;

        if (!aresetn) begin
            scan_phase = PH_IDLE;
            awaited_results.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got.body_valid   = m_tuser[0];
                got.found        = m_tuser[1];
                got.match_index  = m_tdata[7:0];
                got.match_offset = m_tdata[23:8];
                got.match_length = m_tdata[39:24];
                got.next_index   = m_tdata[48:40];
                mismatches += field_diff("m_tdata pad", '0, m_tdata[M_TDATA_W-1:49]);
                if (awaited_results.size() == 0) begin
                    $error("result word with no body pending: tdata %h tuser %h",
                           m_tdata, m_tuser);
                    mismatches++;
                end else begin
                    want = awaited_results.pop_front();
                    mismatches += field_diff("body_valid", want.body_valid, got.body_valid);
                    mismatches += field_diff("found", want.found, got.found);
                    mismatches += field_diff("match_index", want.match_index,
                                             got.match_index);
                    mismatches += field_diff("match_offset", want.match_offset,
                                             got.match_offset);
                    mismatches += field_diff("match_length", want.match_length,
                                             got.match_length);
                    mismatches += field_diff("next_index", want.next_index, got.next_index);
                end
            end

            if (s_tvalid && s_tready) begin
                b = s_tdata[7:0];
                if (s_tuser[0]) begin
                    byte_pos   = '0;
                    rec_total  = '0;
                    rec_idx    = '0;
                    hdr_cnt    = '0;
                    rec_type   = '0;
                    value_left = '0;
                    hit        = '0;
                    q_by_pos   = s_tuser[1];
                    q_type     = s_tdata[23:8];
                    q_start    = s_tdata[31:24];
                    scan_phase = PH_HEAD;
                end
                if (scan_phase != PH_IDLE) begin
                    if (byte_pos != 16'hFFFF) begin
                        pos_now  = byte_pos;
                        byte_pos = byte_pos + 16'd1;
                        case (scan_phase)
                            PH_HEAD: begin
                                if (pos_now == 16'd0)
                                    rec_total = b;
                                if (int'(pos_now) + 1 >= BODY_HEAD_BYTES_DEF) begin
                                    hdr_cnt    = '0;
                                    scan_phase = (rec_total == 8'd0) ? PH_DONE : PH_RHEAD;
                                end
                            end
                            PH_RHEAD: begin
                                case (hdr_cnt)
                                    2'd0: rec_type   = {b, 8'h00};
                                    2'd1: rec_type   = {rec_type[15:8], b};
                                    2'd2: value_left = {b, 8'h00};
                                    default: value_left = {value_left[15:8], b};
                                endcase
                                if (hdr_cnt == 2'd3) begin
                                    hdr_cnt = '0;
                                    if (!hit.found && rec_idx >= q_start &&
                                        (q_by_pos || rec_type == q_type)) begin
                                        hit.found        = 1'b1;
                                        hit.match_index  = rec_idx;
                                        hit.match_offset = pos_now + 16'd1;
                                        hit.match_length = value_left;
                                    end
                                    rec_idx = rec_idx + 8'd1;
                                    if (value_left == 16'd0)
                                        scan_phase = (rec_idx >= rec_total) ? PH_DONE : PH_RHEAD;
                                    else
                                        scan_phase = PH_VALUE;
                                end else begin
                                    hdr_cnt = hdr_cnt + 2'd1;
                                end
                            end
                            PH_VALUE: begin
                                value_left = value_left - 16'd1;
                                if (value_left == 16'd0)
                                    scan_phase = (rec_idx >= rec_total) ? PH_DONE : PH_RHEAD;
                            end
                            default: ;
                        endcase
                    end
                    if (s_tlast) begin
                        want            = hit;
                        want.body_valid = (scan_phase == PH_DONE);
                        want.next_index = hit.found ? {1'b0, hit.match_index} + 9'd1 : 9'd0;
                        awaited_results.push_back(want);
                        scan_phase = PH_IDLE;
                    end
                end
            end
        end
        fail_count    <= mismatches;
        pending_count <= awaited_results.size();
    end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// Top of the tlv_body_check_and_find testbench: clock, reset, body and stray word stimulus,
// random stalls on both channels and the verdict. Depends on tlvbc_pkg and tlvbc_checker.
module testbench;
    import tlvbc_pkg::*;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [S_TUSER_W-1:0] s_tuser;
    logic                 s_tlast;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    int                   fail_count;
    int                   outstanding;

    logic [7:0]           body_q[$];
    bit                   tx_steady = 1'b0;
    bit                   rx_steady = 1'b0;
    bit                   body_open = 1'b0;
    int                   body_bytes_sent = 0;
    logic [15:0]          type_pool[4] = '{16'h0000, 16'hFFFF, 16'h1234, 16'h00A5};

    always #5 aclk = ~aclk;

    tlv_body_check_and_find DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    tlvbc_checker result_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .s_tlast       (s_tlast),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .fail_count    (fail_count),
        .pending_count (outstanding)
    );

    task automatic send_word(input logic [7:0] data, input logic is_first, input logic is_last,
                             input logic by_pos, input logic [15:0] qtype,
                             input logic [7:0] qstart);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 10);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {qstart, qtype, data};
        s_tuser  <= {by_pos, is_first};
        s_tlast  <= is_last;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_body(input logic by_pos, input logic [15:0] qtype,
                             input logic [7:0] qstart, input bit closed);
        int k;
        for (k = 0; k < body_q.size(); k++) begin
            if (k == 0)
                send_word(body_q[k], 1'b1, closed && body_q.size() == 1, by_pos, qtype, qstart);
            else
                send_word(body_q[k], 1'b0, closed && k == body_q.size() - 1,
                          $urandom_range(0, 1), $urandom(), $urandom());
        end
        body_bytes_sent += body_q.size();
        body_open = !closed;
        body_q.delete();
    endtask

    task automatic add_record(input logic [15:0] rtype, input logic [15:0] rlen, input int nval);
        int k;
        body_q.push_back(rtype[15:8]);
        body_q.push_back(rtype[7:0]);
        body_q.push_back(rlen[15:8]);
        body_q.push_back(rlen[7:0]);
        for (k = 0; k < nval; k++)
            body_q.push_back($urandom());
    endtask

    task automatic send_strays(input int n);
        int k;
        for (k = 0; k < n; k++)
            send_word($urandom(), 1'b0, $urandom_range(0, 1), $urandom_range(0, 1),
                      $urandom(), $urandom());
    endtask

    initial begin : result_sink
        int gap;
        int served;
        served = 0;
        forever begin
            if (served % 16 == 0)
                rx_steady = ($urandom_range(0, 2) == 0);
            gap = rx_steady ? 0 : $urandom_range(0, 10);
            if (gap != 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            served++;
        end
    end

    initial begin : watchdog
        #5000000;
        $display("testbench: done, errors");
        $finish;
    end

    initial begin : stimulus
        int          k;
        int          n;
        int          mode;
        int          rlen;
        int          nval;
        logic [15:0] qtype;
        logic [7:0]  qstart;

        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        s_tlast  = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // one-byte bodies: empty and with missing records
        body_q.push_back(8'd0);
        send_body(1'b0, 16'h0000, 8'd0, 1'b1);
        body_q.push_back(8'd5);
        send_body(1'b1, 16'hFFFF, 8'd0, 1'b1);

        // find by type, take by position, start index at count
        for (k = 0; k < 3; k++) begin
            body_q.push_back(8'd2);
            add_record(16'h1234, 16'd0, 0);
            add_record(16'hFFFF, 16'd3, 3);
            send_body(k == 1, 16'hFFFF, (k == 0) ? 8'd0 : k[7:0], 1'b1);
        end

        // last record header cut short
        body_q.push_back(8'd3);
        add_record(16'h0000, 16'd2, 2);
        body_q.push_back(8'h00);
        body_q.push_back(8'hAB);
        send_body(1'b0, 16'h00AB, 8'd0, 1'b1);

        // value runs past the end of the body
        body_q.push_back(8'd1);
        add_record(16'h0000, 16'hFFFF, 4);
        send_body(1'b0, 16'h0000, 8'd0, 1'b1);

        // trailing bytes after the last record
        body_q.push_back(8'd1);
        add_record(16'h5A5A, 16'd1, 1);
        repeat (3) body_q.push_back($urandom());
        send_body(1'b0, 16'h5A5A, 8'd0, 1'b1);

        // words outside any body, then a body dropped by a new first word
        send_strays(3);
        send_word($urandom(), 1'b0, 1'b1, 1'b0, $urandom(), $urandom());
        body_q.push_back(8'd2);
        add_record(16'h0001, 16'd2, 1);
        send_body(1'b1, 16'h0000, 8'd0, 1'b0);

        // 255 records, the top index reachable
        body_q.push_back(8'd255);
        for (k = 0; k < 255; k++)
            add_record(type_pool[k % 4], 16'd0, 0);
        send_body(1'b1, 16'h0000, 8'd254, 1'b1);

        // body longer than the position counter
        tx_steady = 1'b1;
        body_q.push_back(8'd1);
        add_record(16'hBEEF, 16'hFFF0, 16'hFFF0);
        repeat (15) body_q.push_back($urandom());
        send_body(1'b0, 16'hBEEF, 8'd0, 1'b1);

        body_bytes_sent = 0;
        while (body_bytes_sent < 850) begin
            tx_steady = ($urandom_range(0, 3) == 0);
            if (!body_open && $urandom_range(0, 9) == 0) begin
                send_strays($urandom_range(1, 3));
            end else begin
                mode = $urandom_range(0, 15);
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(0, 6);
                body_q.push_back((mode == 3) ? 8'($urandom()) : n[7:0]);
                for (k = 0; k < n; k++) begin
                    rlen = $urandom_range(0, 6);
                    nval = rlen;
                    if ($urandom_range(0, 15) == 0) begin
                        rlen = $urandom_range(0, 65535);
                        nval = $urandom_range(0, 8);
                    end
                    add_record(($urandom_range(0, 4) == 0) ? 16'($urandom())
                                                           : type_pool[$urandom_range(0, 3)],
                               rlen[15:0], nval);
                end
                if ($urandom_range(0, 3) == 0)
                    repeat ($urandom_range(1, 3)) body_q.push_back($urandom());
                if (mode <= 1) begin
                    k = $urandom_range(1, body_q.size());
                    while (body_q.size() > k) void'(body_q.pop_back());
                end
                qtype  = ($urandom_range(0, 5) == 0) ? 16'($urandom())
                                                     : type_pool[$urandom_range(0, 3)];
                qstart = ($urandom_range(0, 7) == 0) ? 8'($urandom()) : 8'($urandom_range(0, n + 1));
                send_body($urandom_range(0, 1), qtype, qstart, mode != 2);
            end
        end

        s_tvalid <= 1'b0;
        repeat (2) @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (24) @(posedge aclk);
        if (outstanding != 0)
            $error("%0d result words never arrived", outstanding);
        if (fail_count == 0 && outstanding == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
